// ===== hdl/u8u16_pkg.sv =====
// Shared types, constants and lead byte classing for the UTF-8 to UTF-16 decoder.
// No dependencies.
package u8u16_pkg;

  localparam int PEND_DEPTH = 5;
  localparam int RUN_MAX    = 6;
  localparam int Q_DEPTH    = 2;
  localparam int Q_AW       = $clog2(Q_DEPTH);

  localparam logic [7:0] LEAD2_MASK = 8'hDF;
  localparam logic [7:0] LEAD2_PAT  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hEF;
  localparam logic [7:0] LEAD3_PAT  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF7;
  localparam logic [7:0] LEAD4_PAT  = 8'hF0;
  localparam logic [7:0] LEAD5_MASK = 8'hFB;
  localparam logic [7:0] LEAD5_PAT  = 8'hF8;
  localparam logic [7:0] LEAD6_MASK = 8'hFD;
  localparam logic [7:0] LEAD6_PAT  = 8'hFC;

  localparam logic [7:0]  BOM_B0    = 8'hEF;
  localparam logic [7:0]  BOM_B1    = 8'hBB;
  localparam logic [7:0]  BOM_B2    = 8'hBF;
  localparam logic [5:0]  CONT_MASK = 6'h3F;
  localparam logic [20:0] SUPP_BASE = 21'h10000;
  localparam logic [5:0]  HI_SURR   = 6'b110110;
  localparam logic [5:0]  LO_SURR   = 6'b110111;

  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_1    = 3'd1;
  localparam logic [2:0] LEN_2    = 3'd2;
  localparam logic [2:0] LEN_3    = 3'd3;
  localparam logic [2:0] LEN_4    = 3'd4;
  localparam logic [2:0] LEN_5    = 3'd5;
  localparam logic [2:0] LEN_6    = 3'd6;

  typedef logic [RUN_MAX-1:0][7:0] run_bytes_t;

  typedef struct packed {
    run_bytes_t bytes;
    logic [2:0] len;
    logic       fin;
  } run_t;

  function automatic logic [2:0] lead_len(input logic [7:0] c);
    logic [2:0] l;
    if (!c[7]) begin
      l = LEN_1;
    end else if ((c & LEAD2_MASK) == c && (c & LEAD2_PAT) == LEAD2_PAT) begin
      l = LEN_2;
    end else if ((c & LEAD3_MASK) == c && (c & LEAD3_PAT) == LEAD3_PAT) begin
      l = LEN_3;
    end else if ((c & LEAD4_MASK) == c && (c & LEAD4_PAT) == LEAD4_PAT) begin
      l = LEN_4;
    end else if ((c & LEAD5_MASK) == c && (c & LEAD5_PAT) == LEAD5_PAT) begin
      l = LEN_5;
    end else if ((c & LEAD6_MASK) == c && (c & LEAD6_PAT) == LEAD6_PAT) begin
      l = LEN_6;
    end else begin
      l = LEN_NONE;
    end
    return l;
  endfunction

endpackage

// ===== hdl/u8u16_front.sv =====
// Front end: collects the bytes of one sequence and hands each run to the queue when complete or at the final byte.
// Depends on u8u16_pkg.
module u8u16_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  input  logic [7:0]       in_text_byte,
  input  logic             in_final_byte,
  input  logic             q_full,
  output logic             q_push,
  output u8u16_pkg::run_t  q_run
);

  logic [u8u16_pkg::PEND_DEPTH-1:0][7:0] pend_r;
  logic [2:0] count_r, count_nxt;
  logic [2:0] seqlen_r, seqlen_nxt;
  logic [2:0] blen;
  logic [2:0] n_ext;
  logic       hold;
  logic       acc;

  assign acc   = in_push && !q_full;
  assign blen  = u8u16_pkg::lead_len(in_text_byte);
  assign n_ext = count_r + 3'd1;

  always_comb begin
    if (seqlen_r == u8u16_pkg::LEN_NONE) begin
      hold = (blen >= u8u16_pkg::LEN_2) && !in_final_byte;
    end else begin
      hold = (n_ext < seqlen_r) && !in_final_byte;
    end
  end

  always_comb begin
    for (int k = 0; k < u8u16_pkg::PEND_DEPTH; k++) begin
      q_run.bytes[k] = (count_r == 3'(k)) ? in_text_byte : pend_r[k];
    end
    q_run.bytes[u8u16_pkg::RUN_MAX-1] = in_text_byte;
    q_run.len = n_ext;
    q_run.fin = in_final_byte;
  end

  assign q_push = acc && !hold;

  always_comb begin
    count_nxt  = count_r;
    seqlen_nxt = seqlen_r;
    if (acc) begin
      if (hold) begin
        count_nxt = n_ext;
        if (seqlen_r == u8u16_pkg::LEN_NONE) begin
          seqlen_nxt = blen;
        end
      end else begin
        count_nxt  = 3'd0;
        seqlen_nxt = u8u16_pkg::LEN_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 3'd0;
      seqlen_r <= u8u16_pkg::LEN_NONE;
    end else begin
      count_r  <= count_nxt;
      seqlen_r <= seqlen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && hold && count_r < 3'(u8u16_pkg::PEND_DEPTH)) begin
      pend_r[count_r] <= in_text_byte;
    end
  end

endmodule

// ===== hdl/u8u16_queue.sv =====
// Short run queue between front end and back end.
// Depends on u8u16_pkg.
module u8u16_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  u8u16_pkg::run_t  push_run,
  output logic             full,
  input  logic             pop,
  output u8u16_pkg::run_t  pop_run,
  output logic             empty
);

  u8u16_pkg::run_t ent_r [u8u16_pkg::Q_DEPTH];
  logic [u8u16_pkg::Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [u8u16_pkg::Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [u8u16_pkg::Q_AW:0]   cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign full    = cnt_r == (u8u16_pkg::Q_AW+1)'(u8u16_pkg::Q_DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_run = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == u8u16_pkg::Q_AW'(u8u16_pkg::Q_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == u8u16_pkg::Q_AW'(u8u16_pkg::Q_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_run;
    end
  end

endmodule

// ===== hdl/u8u16_back.sv =====
// Back end: decodes one queued run a sequence at a time into the output word register, holding while it is full.
// Depends on u8u16_pkg.
module u8u16_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  u8u16_pkg::run_t  q_run,
  output logic             q_pop,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [15:0]      out_code_unit,
  output logic             out_is_terminator,
  output logic             out_bom_found,
  output logic             out_run_end
);

  logic                  busy_r, busy_nxt;
  u8u16_pkg::run_bytes_t win_r;
  logic [2:0]            rem_r;
  logic                  fin_r;
  logic                  first_r;
  logic                  lo_pend_r;
  logic [9:0]            lo_r;
  logic                  text_start_r, text_start_nxt;
  logic                  bom_seen_r, bom_seen_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [15:0]           unit_r;
  logic                  term_r, bomf_r, rend_r;

  logic [7:0]  c, b1, b2, b3;
  logic [2:0]  clen;
  logic        fits;
  logic        emit, term, bomf, rend, lo_set, bom_set, term_step;
  logic [15:0] unit;
  logic [2:0]  adv;
  logic [2:0]  rem_after;
  logic [20:0] cp;
  logic [19:0] u;
  logic        out_adv, step, finish, load;

  assign c    = win_r[0];
  assign b1   = win_r[1];
  assign b2   = win_r[2];
  assign b3   = win_r[3];
  assign clen = u8u16_pkg::lead_len(c);
  assign fits = (clen >= u8u16_pkg::LEN_2) && (clen <= rem_r);

  assign cp = {c[2:0], b1[5:0] & u8u16_pkg::CONT_MASK, b2[5:0] & u8u16_pkg::CONT_MASK,
               b3[5:0] & u8u16_pkg::CONT_MASK};
  assign u  = 20'(cp - u8u16_pkg::SUPP_BASE);

  always_comb begin
    emit      = 1'b0;
    term      = 1'b0;
    bomf      = 1'b0;
    rend      = 1'b0;
    unit      = 16'd0;
    adv       = 3'd0;
    lo_set    = 1'b0;
    bom_set   = 1'b0;
    term_step = 1'b0;
    if (busy_r) begin
      if (lo_pend_r) begin
        emit = 1'b1;
        unit = {u8u16_pkg::LO_SURR, lo_r};
        rend = !fin_r;
      end else if (rem_r != 3'd0) begin
        if (clen == u8u16_pkg::LEN_1) begin
          emit = 1'b1;
          unit = {8'd0, c};
          rend = !fin_r;
          adv  = 3'd1;
        end else if (fits) begin
          adv = clen;
          case (clen)
            u8u16_pkg::LEN_2: begin
              emit = 1'b1;
              unit = {5'd0, c[4:0], b1[5:0]};
              rend = !fin_r;
            end
            u8u16_pkg::LEN_3: begin
              if (first_r && text_start_r && c == u8u16_pkg::BOM_B0 &&
                  b1 == u8u16_pkg::BOM_B1 && b2 == u8u16_pkg::BOM_B2) begin
                bom_set = 1'b1;
              end else begin
                emit = 1'b1;
                unit = {c[3:0], b1[5:0], b2[5:0]};
                rend = !fin_r;
              end
            end
            u8u16_pkg::LEN_4: begin
              emit   = 1'b1;
              unit   = {u8u16_pkg::HI_SURR, u[19:10]};
              lo_set = 1'b1;
            end
            default: begin
            end
          endcase
        end else begin
          adv = 3'd1;
        end
      end else begin
        emit      = 1'b1;
        term      = 1'b1;
        bomf      = bom_seen_r;
        rend      = 1'b1;
        term_step = 1'b1;
      end
    end
  end

  assign out_adv   = !out_valid_r || out_pop;
  assign step      = busy_r && (!emit || out_adv);
  assign rem_after = rem_r - adv;
  assign finish    = step && (term_step || (!fin_r && rem_after == 3'd0 && !lo_set));
  assign load      = !q_empty && (!busy_r || finish);
  assign q_pop     = load;

  always_comb begin
    busy_nxt       = busy_r;
    text_start_nxt = text_start_r;
    bom_seen_nxt   = bom_seen_r;
    out_valid_nxt  = out_valid_r;
    if (finish) begin
      busy_nxt = 1'b0;
    end
    if (load) begin
      busy_nxt = 1'b1;
    end
    if (step && bom_set) begin
      bom_seen_nxt = 1'b1;
    end
    if (finish) begin
      text_start_nxt = fin_r;
      if (fin_r) begin
        bom_seen_nxt = 1'b0;
      end
    end
    if (step && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      lo_pend_r    <= 1'b0;
      text_start_r <= 1'b1;
      bom_seen_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      text_start_r <= text_start_nxt;
      bom_seen_r   <= bom_seen_nxt;
      out_valid_r  <= out_valid_nxt;
      if (load) begin
        lo_pend_r <= 1'b0;
      end else if (step) begin
        lo_pend_r <= lo_set;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      win_r   <= q_run.bytes;
      rem_r   <= q_run.len;
      fin_r   <= q_run.fin;
      first_r <= 1'b1;
    end else if (step) begin
      win_r   <= win_r >> {adv, 3'b000};
      rem_r   <= rem_after;
      first_r <= 1'b0;
    end
    if (step && lo_set) begin
      lo_r <= u[9:0];
    end
    if (step && emit) begin
      unit_r <= unit;
      term_r <= term;
      bomf_r <= bomf;
      rend_r <= rend;
    end
  end

  assign out_empty         = !out_valid_r;
  assign out_code_unit     = unit_r;
  assign out_is_terminator = term_r;
  assign out_bom_found     = bomf_r;
  assign out_run_end       = rend_r;

endmodule

// ===== hdl/utf8_to_utf16_decoder.sv =====
// UTF-8 to UTF-16 decoder top level: front end, run queue and back end.
// Throughput: one byte per cycle while the queue is not full; the back end emits one word
// per cycle while popped; a run's words (surrogate pair, flush, terminator) go in turn.
// Path: a run passes the queue entry, the back-end window and the output word register.
// Reset: synchronous active-low rst_n; clears all control state, starts a new text.
// Depends on u8u16_pkg, u8u16_front, u8u16_queue, u8u16_back.
module utf8_to_utf16_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_text_byte,
  input  logic        in_final_byte,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] out_code_unit,
  output logic        out_is_terminator,
  output logic        out_bom_found,
  output logic        out_run_end
);

  u8u16_pkg::run_t push_run, pop_run;
  logic q_push, q_full, q_pop, q_empty;

  assign full = q_full;

  u8u16_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (push),
    .in_text_byte  (in_text_byte),
    .in_final_byte (in_final_byte),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_run         (push_run)
  );

  u8u16_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_run (push_run),
    .full     (q_full),
    .pop      (q_pop),
    .pop_run  (pop_run),
    .empty    (q_empty)
  );

  u8u16_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_run             (pop_run),
    .q_pop             (q_pop),
    .out_empty         (empty),
    .out_pop           (pop),
    .out_code_unit     (out_code_unit),
    .out_is_terminator (out_is_terminator),
    .out_bom_found     (out_bom_found),
    .out_run_end       (out_run_end)
  );

`ifndef SYNTHESIS
  a_term_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_is_terminator) |-> (out_run_end && out_code_unit == 16'd0))
    else $error("terminator word without run end or with nonzero unit");

  a_bom_on_term: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_bom_found) |-> out_is_terminator)
    else $error("bom flag on a non-terminator word");

  a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("back end took a run from an empty queue");
`endif

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for utf8_to_utf16_decoder: directed and random UTF-8 text in, UTF-16
// words checked against an in-bench decoder model with random stalls on both sides.
// Depends only on the decoder RTL and its package.
`timescale 1ns / 100ps

module testbench;

  localparam int LIMIT = 200000;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic       drain;
  } text_item_t;

  typedef struct packed {
    logic [15:0] code;
    logic        term;
    logic        bom;
    logic        tail;
  } word_t;

  // {final, byte}: BOM text, lead widths 1-4, then plain/stray bytes and more, then a cut-off one
  localparam logic [8:0] DIRECTED [25] = '{
    9'h0EF, 9'h0BB, 9'h0BF, 9'h07F, 9'h0DF, 9'h0BF, 9'h0F7, 9'h0BF, 9'h0BF, 9'h1BF,
    9'h000, 9'h0C0, 9'h080, 9'h0E0, 9'h080, 9'h080, 9'h0F0, 9'h090, 9'h080, 9'h080,
    9'h0FE, 9'h1FF,
    9'h0F0, 9'h0C3, 9'h1A9
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_text_byte = 8'h00;
  logic        in_final_byte = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [15:0] out_code_unit;
  logic        out_is_terminator;
  logic        out_bom_found;
  logic        out_run_end;

  text_item_t  text_bytes[$];
  word_t       expected_units[$];

  // decoder state mirror
  logic [7:0]  seq_bytes [5];
  int          seq_held = 0;
  int          seq_len = 0;
  logic        at_text_start = 1'b1;
  logic        bom_stripped = 1'b0;

  int          n_sent = 0;
  int          n_words = 0;
  int          n_err = 0;
  int          rx_hold = 0;
  int          cyc = 0;
  wire         burst = (n_sent >= 150) && (n_sent < 240);

  utf8_to_utf16_decoder u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_text_byte     (in_text_byte),
    .in_final_byte    (in_final_byte),
    .empty            (empty),
    .pop              (pop),
    .out_code_unit    (out_code_unit),
    .out_is_terminator(out_is_terminator),
    .out_bom_found    (out_bom_found),
    .out_run_end      (out_run_end)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int seq_class(input logic [7:0] c);
    casez (c)
      8'b0???????: return 1;
      8'b110?????: return 2;
      8'b1110????: return 3;
      8'b11110???: return 4;
      8'b111110??: return 5;
      8'b1111110?: return 6;
      default:     return 0;
    endcase
  endfunction

  task automatic add_byte(input logic [7:0] b, input logic fin);
    text_item_t it;
    it.data  = b;
    it.fin   = fin;
    it.drain = (text_bytes.size() == 25) || (text_bytes.size() == 300);
    text_bytes.push_back(it);
  endtask

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    n_err++;
    $display("[%0t] mismatch on word %0d: %s got %h expected %h", $time, n_words, what, got,
             want);
  endtask

  // decode one accepted byte, queue the words it produces
  task automatic decode_byte(input logic [7:0] b, input logic fin);
    logic [7:0]  run_b [6];
    word_t       res [8];
    int          n;
    int          k;
    int          i;
    int          len;
    logic [7:0]  c;
    logic [20:0] v;
    logic [19:0] u;
    k = 0;
    if (seq_len == 0) begin
      len = seq_class(b);
      if (len >= 2 && !fin) begin
        seq_bytes[0] = b;
        seq_held = 1;
        seq_len = len;
        return;
      end
      run_b[0] = b;
      n = 1;
    end else begin
      n = seq_held;
      for (i = 0; i < n; i++) run_b[i] = seq_bytes[i];
      run_b[n] = b;
      n++;
      if (n < seq_len && !fin) begin
        seq_bytes[n-1] = b;
        seq_held = n;
        return;
      end
    end
    i = 0;
    while (i < n) begin
      c = run_b[i];
      len = seq_class(c);
      if (len == 1) begin
        res[k] = {8'h00, c, 3'b000};
        k++;
        i++;
      end else if (len >= 2 && i + len - 1 < n) begin
        case (len)
          2: begin
            res[k] = {5'b00000, c[4:0], run_b[i+1][5:0], 3'b000};
            k++;
          end
          3: begin
            if (i == 0 && at_text_start && c == 8'hEF && run_b[1] == 8'hBB &&
                run_b[2] == 8'hBF) begin
              bom_stripped = 1'b1;
            end else begin
              res[k] = {c[3:0], run_b[i+1][5:0], run_b[i+2][5:0], 3'b000};
              k++;
            end
          end
          4: begin
            v = {c[2:0], run_b[i+1][5:0], run_b[i+2][5:0], run_b[i+3][5:0]};
            v = v - 21'h10000;
            u = v[19:0];
            res[k]   = {6'b110110, u[19:10], 3'b000};
            res[k+1] = {6'b110111, u[9:0], 3'b000};
            k += 2;
          end
          default: ;
        endcase
        i += len;
      end else begin
        i++;
      end
    end
    seq_held = 0;
    seq_len = 0;
    at_text_start = 1'b0;
    if (fin) begin
      res[k] = {16'h0000, 1'b1, bom_stripped, 1'b0};
      k++;
      at_text_start = 1'b1;
      bom_stripped = 1'b0;
    end
    if (k > 0) res[k-1].tail = 1'b1;
    for (i = 0; i < k; i++) expected_units.push_back(res[i]);
  endtask

  // driver
  always @(posedge clk) begin : drv
    text_item_t nxt;
    if (rst_n) begin
      if (push && !full) begin
        decode_byte(in_text_byte, in_final_byte);
        n_sent++;
      end
      if (!push || !full) begin
        if (text_bytes.size() > 0 && !(text_bytes[0].drain && expected_units.size() > 0) &&
            (burst || $urandom_range(99) >= 29)) begin
          nxt = text_bytes.pop_front();
          push <= 1'b1;
          in_text_byte <= nxt.data;
          in_final_byte <= nxt.fin;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : mon
    word_t want;
    if (rst_n) begin
      if (pop && !empty) begin
        n_words++;
        if (expected_units.size() == 0) begin
          report("word with nothing expected", out_code_unit, 16'h0000);
        end else begin
          want = expected_units.pop_front();
          if (out_code_unit !== want.code) report("code_unit", out_code_unit, want.code);
          if (out_is_terminator !== want.term)
            report("is_terminator", {15'd0, out_is_terminator}, {15'd0, want.term});
          if (out_bom_found !== want.bom)
            report("bom_found", {15'd0, out_bom_found}, {15'd0, want.bom});
          if (out_run_end !== want.tail)
            report("run_end", {15'd0, out_run_end}, {15'd0, want.tail});
        end
        if (n_words == 40) rx_hold = 150;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        pop <= 1'b0;
      end else begin
        pop <= burst || ($urandom_range(99) >= 29);
      end
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc >= LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stim
    logic [7:0] seq_b [6];
    int         cls;
    int         len;
    int         i;
    logic       fin_b;
    logic       fresh;
    for (i = 0; i < 25; i++) add_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
    fresh = 1'b1;
    while (text_bytes.size() < 369) begin
      cls = $urandom_range(8);
      case (cls)
        0, 1: begin
          len = 1;
          seq_b[0] = 8'($urandom_range(127));
        end
        2: begin
          len = 2;
          seq_b[0] = 8'hC0 | 8'($urandom_range(31));
        end
        3: begin
          len = 3;
          seq_b[0] = 8'hE0 | 8'($urandom_range(15));
        end
        4: begin
          len = 4;
          seq_b[0] = 8'hF0 | 8'($urandom_range(7));
        end
        5: begin
          len = 5;
          seq_b[0] = 8'hF8 | 8'($urandom_range(3));
        end
        6: begin
          len = 6;
          seq_b[0] = 8'hFC | 8'($urandom_range(1));
        end
        default: begin
          len = 1;
          seq_b[0] = 8'($urandom_range(255));
        end
      endcase
      for (i = 1; i < len; i++)
        seq_b[i] = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) :
                   (8'h80 | 8'($urandom_range(63)));
      if (fresh && $urandom_range(4) == 0) begin
        len = 3;
        seq_b[0] = 8'hEF;
        seq_b[1] = 8'hBB;
        seq_b[2] = 8'hBF;
      end
      fin_b = ($urandom_range(5) == 0);
      // cut the sequence short at end of text
      if (fin_b && len > 1 && $urandom_range(1) == 0) len = $urandom_range(len - 1, 1);
      for (i = 0; i < len; i++) add_byte(seq_b[i], fin_b && (i == len - 1));
      fresh = fin_b;
    end
    add_byte(8'h41, 1'b1);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (text_bytes.size() != 0 || push);
    while (expected_units.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_err == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/u8u16_pkg.sv
hdl/u8u16_front.sv
hdl/u8u16_queue.sv
hdl/u8u16_back.sv
hdl/utf8_to_utf16_decoder.sv
verif/testbench.sv
